// ----- rtl/core/centered_fft_ifft_frame_assert.svh -----
// Assertion macros used by the checker file of this block.
// Each macro asserts one property on the rising edge of clk, disabled in reset.
`ifndef CENTERED_FFT_IFFT_FRAME_ASSERT_SVH
`define CENTERED_FFT_IFFT_FRAME_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFIF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cfif_pkg.sv -----
`default_nettype none

package cfif_pkg;

    localparam int POINTS      = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int LG          = $clog2(POINTS);
    localparam int HALF        = POINTS / 2;
    localparam int QUARTER     = POINTS / 4;
    localparam int DW          = SAMPLE_BITS + LG + 1;
    localparam int TW_BITS     = 26;
    localparam int OUT_BITS    = 20;
    localparam int IDX_BITS    = 8;
    localparam int SH          = LG / 2;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic signed [24:0] INV_SQRT2_Q24 = 25'sd11863283;
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = 20'sd524287;
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = -20'sd524288;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(POINTS - 1);

    typedef logic [LG-1:0] addr_t;
    typedef logic signed [DW-1:0] data_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } in_t;

    typedef struct packed {
        logic                       out_valid;
        logic signed [OUT_BITS-1:0] bin_re;
        logic signed [OUT_BITS-1:0] bin_im;
        logic [IDX_BITS-1:0]        bin_index;
        logic                       frame_end;
    } out_t;

    typedef struct packed {
        data_t re;
        data_t im;
    } cplx_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] re;
        logic signed [OUT_BITS-1:0] im;
    } res_t;

    typedef struct packed {
        logic signed [TW_BITS-1:0] re;
        logic signed [TW_BITS-1:0] im;
    } tw_t;

    typedef logic [QUARTER-1:0][24:0] trig_tab_t;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (ONE_Q30 >> 1)) >> 30;
    endfunction

    // One Taylor term divisor per step, sine and cosine series.
    function automatic logic [63:0] taylor_div(input logic [63:0] m, input logic is_sin,
                                               input int step);
        if (is_sin) begin
            unique case (step)
                0: return m / 156;
                1: return m / 110;
                2: return m / 72;
                3: return m / 42;
                4: return m / 20;
                default: return m / 6;
            endcase
        end
        unique case (step)
            0: return m / 182;
            1: return m / 132;
            2: return m / 90;
            3: return m / 56;
            4: return m / 30;
            5: return m / 12;
            default: return m / 2;
        endcase
    endfunction

    // Q1.24 sine or cosine of 2*pi*r/POINTS, evaluated at elaboration.
    function automatic logic [24:0] trig_value(input int r, input logic is_sin);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        int steps;
        x = (64'd2 * PI_Q30 * 64'(r) + 64'(HALF)) / POINTS;
        x2 = mul_q30(x, x);
        t = ONE_Q30;
        steps = is_sin ? 6 : 7;
        for (int i = 0; i < steps; i++) begin
            d = taylor_div(mul_q30(x2, t), is_sin, i);
            t = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
        end
        if (is_sin) begin
            t = (mul_q30(x, t) + 64'd32) >> 6;
        end else begin
            t = (t + 64'd32) >> 6;
        end
        return t[24:0];
    endfunction

    function automatic trig_tab_t build_trig(input logic is_sin);
        trig_tab_t tab;
        for (int r = 0; r < QUARTER; r++) begin
            tab[r] = trig_value(r, is_sin);
        end
        return tab;
    endfunction

    localparam trig_tab_t COS_TAB = build_trig(1'b0);
    localparam trig_tab_t SIN_TAB = build_trig(1'b1);

    // exp(-i*2*pi*t/POINTS) for t below POINTS/2, conjugated for the inverse.
    function automatic tw_t twiddle(input logic [LG-2:0] t, input logic inv);
        logic [LG-3:0] r;
        logic signed [TW_BITS-1:0] c;
        logic signed [TW_BITS-1:0] s;
        tw_t w;
        r = t[LG-3:0];
        c = $signed({1'b0, COS_TAB[r]});
        s = $signed({1'b0, SIN_TAB[r]});
        if (t[LG-2]) begin
            w.re = -s;
            w.im = -c;
        end else begin
            w.re = c;
            w.im = -s;
        end
        if (inv) begin
            w.im = -w.im;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfif_bfly.sv -----
`default_nettype none

module cfif_bfly (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cfif_pkg::cplx_t a,
    input  cfif_pkg::cplx_t b,
    input  cfif_pkg::tw_t   w,
    input  cfif_pkg::addr_t tag_in,
    output logic            out_valid,
    output cfif_pkg::cplx_t x,
    output cfif_pkg::cplx_t y,
    output cfif_pkg::addr_t tag_out
);
    import cfif_pkg::*;

    localparam int PW = TW_BITS + DW;
    localparam logic signed [PW:0] ROUND_HALF = (PW + 1)'(1) << 23;

    logic signed [PW-1:0] p_rr_reg;
    logic signed [PW-1:0] p_ii_reg;
    logic signed [PW-1:0] p_ri_reg;
    logic signed [PW-1:0] p_ir_reg;
    cplx_t a1_reg;
    addr_t tag1_reg;
    logic  v1_reg;
    logic  v2_reg;
    cplx_t x_reg;
    cplx_t y_reg;
    addr_t tag2_reg;

    logic signed [PW:0] sum_r;
    logic signed [PW:0] sum_i;
    logic signed [PW:0] prod_r;
    logic signed [PW:0] prod_i;
    logic signed [PW:0] a_r;
    logic signed [PW:0] a_i;
    logic signed [PW:0] xr_full;
    logic signed [PW:0] xi_full;
    logic signed [PW:0] yr_full;
    logic signed [PW:0] yi_full;

    always_comb
    begin
        sum_r = {p_rr_reg[PW-1], p_rr_reg} - {p_ii_reg[PW-1], p_ii_reg};
        sum_i = {p_ri_reg[PW-1], p_ri_reg} + {p_ir_reg[PW-1], p_ir_reg};
        prod_r = (sum_r + ROUND_HALF) >>> 24;
        prod_i = (sum_i + ROUND_HALF) >>> 24;
        a_r = {{(PW + 1 - DW){a1_reg.re[DW-1]}}, a1_reg.re};
        a_i = {{(PW + 1 - DW){a1_reg.im[DW-1]}}, a1_reg.im};
        xr_full = a_r + prod_r;
        xi_full = a_i + prod_i;
        yr_full = a_r - prod_r;
        yi_full = a_i - prod_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg <= $signed(w.re) * $signed(b.re);
        p_ii_reg <= $signed(w.im) * $signed(b.im);
        p_ri_reg <= $signed(w.re) * $signed(b.im);
        p_ir_reg <= $signed(w.im) * $signed(b.re);
        a1_reg   <= a;
        tag1_reg <= tag_in;
        x_reg.re <= xr_full[DW-1:0];
        x_reg.im <= xi_full[DW-1:0];
        y_reg.re <= yr_full[DW-1:0];
        y_reg.im <= yi_full[DW-1:0];
        tag2_reg <= tag1_reg;
    end

    assign out_valid = v2_reg;
    assign x = x_reg;
    assign y = y_reg;
    assign tag_out = tag2_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cfif_engine.sv -----
`default_nettype none

module cfif_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic            inv,
    input  logic            load_we,
    input  cfif_pkg::addr_t load_addr,
    input  cfif_pkg::in_t   load_wdata,
    input  cfif_pkg::addr_t res_raddr,
    output cfif_pkg::res_t  res_rdata,
    output logic            busy
);
    import cfif_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_STAGE, S_DRAIN, S_FIN, S_FLUSH} state_t;

    localparam int SW  = (LG > 1) ? $clog2(LG) : 1;
    localparam int WAW = LG + 1;
    localparam int FW  = DW + 27;
    localparam logic FIN_BANK = 1'((LG - 1) % 2);
    localparam logic [SW-1:0] LAST_STAGE = SW'(LG - 1);
    localparam logic [LG-2:0] LAST_J = '1;
    localparam addr_t LAST_N = '1;
    localparam logic signed [FW-1:0] ODD_RND  = FW'(1) << (23 + SH);
    localparam logic signed [FW-1:0] EVEN_RND = FW'(1) << (SH - 1);
    localparam logic signed [FW-1:0] SAT_MAX  = FW'(OUT_MAX);
    localparam logic signed [FW-1:0] SAT_MIN  = FW'(OUT_MIN);

    function automatic data_t widen(input logic signed [SAMPLE_BITS-1:0] v);
        return {{(DW - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    // Output scaling by 1/sqrt(POINTS) with rounding, then saturation.
    function automatic logic signed [OUT_BITS-1:0] finish(input data_t v);
        logic signed [FW-1:0] wide;
        logic signed [FW-1:0] scaled;
        wide = {{(FW - DW){v[DW-1]}}, v};
        if (LG % 2 == 1) begin
            scaled = (wide * FW'(INV_SQRT2_Q24) + ODD_RND) >>> (24 + SH);
        end else begin
            scaled = (wide + EVEN_RND) >>> SH;
        end
        if (scaled > SAT_MAX) begin
            return OUT_MAX;
        end
        if (scaled < SAT_MIN) begin
            return OUT_MIN;
        end
        return scaled[OUT_BITS-1:0];
    endfunction

    state_t          state_reg;
    logic [SW-1:0]   stage_reg;
    logic [LG-2:0]   j_reg;
    logic            ph_reg;
    logic [1:0]      drain_reg;
    logic            inv_reg;
    addr_t           n_reg;
    logic            iss_v_reg;
    logic            fin_v_reg;
    logic            y_v_reg;
    tw_t             tw_reg;
    addr_t           dest_reg;
    addr_t           fin_n_reg;
    addr_t           y_addr_reg;
    cplx_t           y_reg;

    in_t   load_mem [POINTS];
    cplx_t work_mem [2*POINTS];
    res_t  res_mem  [POINTS];
    in_t   ld_a_reg;
    in_t   ld_b_reg;
    cplx_t wk_a_reg;
    cplx_t wk_b_reg;
    res_t  res_rd_reg;

    logic            issue;
    logic [LG-2:0]   k_mask;
    logic [LG-2:0]   k_val;
    logic [SW:0]     t_shift;
    logic [LG-2:0]   t_val;
    addr_t           dest_val;
    addr_t           h_val;
    logic            rbank;
    addr_t           ld_addr_a;
    addr_t           ld_addr_b;
    addr_t           fin_src;
    logic [WAW-1:0]  wk_addr_a;
    logic [WAW-1:0]  wk_addr_b;
    cplx_t           bf_a;
    cplx_t           bf_b;
    logic            bf_out_v;
    cplx_t           bf_x;
    cplx_t           bf_y;
    addr_t           bf_tag;
    logic            wk_we;
    logic [WAW-1:0]  wk_waddr;
    cplx_t           wk_wdata;

    // Stockham indexing: butterfly j of stage s reads j and j+POINTS/2 and
    // writes o and o+h with h = 2^s, k = j mod h, o = 2*(j-k)+k.
    always_comb
    begin
        issue     = (state_reg == S_STAGE) && !ph_reg;
        k_mask    = (LG - 1)'((1 << stage_reg) - 1);
        k_val     = j_reg & k_mask;
        t_shift   = (SW + 1)'(LG - 1) - {1'b0, stage_reg};
        t_val     = k_val << t_shift;
        dest_val  = (addr_t'(j_reg & ~k_mask) << 1) | addr_t'(k_val);
        h_val     = addr_t'(1) << stage_reg;
        rbank     = ~stage_reg[0];
        ld_addr_a = {inv_reg, j_reg};
        ld_addr_b = {~inv_reg, j_reg};
        fin_src   = inv_reg ? n_reg : {~n_reg[LG-1], n_reg[LG-2:0]};
        wk_addr_a = (state_reg == S_FIN) ? {FIN_BANK, fin_src} : {rbank, 1'b0, j_reg};
        wk_addr_b = {rbank, 1'b1, j_reg};
        if (stage_reg == '0)
        begin
            bf_a.re = widen(ld_a_reg.sample_re);
            bf_a.im = widen(ld_a_reg.sample_im);
            bf_b.re = widen(ld_b_reg.sample_re);
            bf_b.im = widen(ld_b_reg.sample_im);
        end
        else
        begin
            bf_a = wk_a_reg;
            bf_b = wk_b_reg;
        end
        wk_we = bf_out_v || y_v_reg;
        if (bf_out_v)
        begin
            wk_waddr = {stage_reg[0], bf_tag};
            wk_wdata = bf_x;
        end
        else
        begin
            wk_waddr = {stage_reg[0], y_addr_reg};
            wk_wdata = y_reg;
        end
    end

    cfif_bfly u_bfly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_v_reg),
        .a         (bf_a),
        .b         (bf_b),
        .w         (tw_reg),
        .tag_in    (dest_reg),
        .out_valid (bf_out_v),
        .x         (bf_x),
        .y         (bf_y),
        .tag_out   (bf_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= '0;
            j_reg     <= '0;
            ph_reg    <= 1'b0;
            drain_reg <= '0;
            inv_reg   <= 1'b0;
            n_reg     <= '0;
            iss_v_reg <= 1'b0;
            fin_v_reg <= 1'b0;
            y_v_reg   <= 1'b0;
        end
        else
        begin
            iss_v_reg <= issue;
            fin_v_reg <= (state_reg == S_FIN);
            y_v_reg   <= bf_out_v;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        state_reg <= S_STAGE;
                        inv_reg   <= inv;
                        stage_reg <= '0;
                        j_reg     <= '0;
                        ph_reg    <= 1'b0;
                    end
                end
                S_STAGE:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= j_reg + 1'b1;
                        if (j_reg == LAST_J)
                        begin
                            state_reg <= S_DRAIN;
                            drain_reg <= '0;
                        end
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd2)
                    begin
                        if (stage_reg == LAST_STAGE)
                        begin
                            state_reg <= S_FIN;
                            n_reg     <= '0;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_STAGE;
                        end
                    end
                end
                S_FIN:
                begin
                    n_reg <= n_reg + 1'b1;
                    if (n_reg == LAST_N)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tw_reg     <= twiddle(t_val, inv_reg);
        dest_reg   <= dest_val;
        fin_n_reg  <= n_reg;
        y_reg      <= bf_y;
        y_addr_reg <= bf_tag | h_val;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            load_mem[load_addr] <= load_wdata;
        end
        ld_a_reg <= load_mem[ld_addr_a];
        ld_b_reg <= load_mem[ld_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            work_mem[wk_waddr] <= wk_wdata;
        end
        wk_a_reg <= work_mem[wk_addr_a];
        wk_b_reg <= work_mem[wk_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (fin_v_reg)
        begin
            res_mem[fin_n_reg] <= '{re: finish(wk_a_reg.re), im: finish(wk_a_reg.im)};
        end
        res_rd_reg <= res_mem[res_raddr];
    end

    assign res_rdata = res_rd_reg;
    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/centered_fft_ifft_frame.sv -----
// Centered FFT / IFFT frame engine, 256 complex points, Q1.15 in, 20-bit out.
// Requests carry one complex sample on sample and are taken on a rising edge
// with start high and busy low. Every request is answered by exactly one result
// on result, shown with strobe in the cycle after the request. The
// result carries the bin at the same frame position from the frame finished
// before; until a first frame is finished out_valid and all fields are zero.
// Requests may come in every cycle while a frame is loading. The request that
// completes a frame raises busy on the next cycle while the transform runs:
// eight Stockham stages of 128 butterflies, each butterfly issue followed by an
// idle phase because the work memory has one write port and every butterfly
// writes two entries, plus a drain state after each stage and a scaling pass
// into the result memory; no request is taken until busy falls again.
// The APB register at address 0 holds the mode bit (0 forward with centered
// output, 1 inverse from centered input); it is sampled when a frame completes.
// Reset clears the frame position, the mode and the finished-frame flag; the
// sample memories are not cleared. The receiver cannot hold results off, so
// nothing ever waits on the output side.
`default_nettype none

module centered_fft_ifft_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             start,
    input  cfif_pkg::in_t    sample,
    output logic             busy,
    output logic             strobe,
    output cfif_pkg::out_t   result
);
    import cfif_pkg::*;

    localparam addr_t LAST_POS = '1;
    localparam logic [1:0] MODE_ADDR = 2'd0;

    logic           inv_reg;
    addr_t          pos_reg;
    logic           have_reg;
    logic           strobe_reg;
    logic           have_d_reg;
    addr_t          pos_d_reg;

    logic           accept;
    logic           cfg_write;
    logic           eng_busy;
    res_t           res_rdata;

    // A request is taken whenever the engine is not transforming.
    assign accept    = start && !eng_busy;
    // Only the mode register is writable; other addresses are ignored.
    assign cfg_write = psel && penable && pwrite && (paddr == MODE_ADDR);

    // The engine stores the sample at the current position and reads the
    // finished bin at that same position; the read data is registered and comes
    // in the cycle after the request, aligned with strobe.
    cfif_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept && (pos_reg == LAST_POS)),
        .inv        (inv_reg),
        .load_we    (accept),
        .load_addr  (pos_reg),
        .load_wdata (sample),
        .res_raddr  (pos_reg),
        .res_rdata  (res_rdata),
        .busy       (eng_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg    <= 1'b0;
            pos_reg    <= '0;
            have_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            have_d_reg <= 1'b0;
            pos_d_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                inv_reg <= pwdata[0];
            end
            strobe_reg <= accept;
            if (accept)
            begin
                have_d_reg <= have_reg;
                pos_d_reg  <= pos_reg;
                pos_reg    <= pos_reg + 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    // Before the first finished frame every field reads as zero.
    always_comb
    begin
        result.out_valid = have_d_reg;
        result.bin_re    = have_d_reg ? res_rdata.re : '0;
        result.bin_im    = have_d_reg ? res_rdata.im : '0;
        result.bin_index = have_d_reg ? IDX_BITS'(pos_d_reg) : '0;
        result.frame_end = have_d_reg && (pos_d_reg == LAST_POS);
    end

    assign strobe = strobe_reg;
    assign busy   = eng_busy;
    assign pready = 1'b1;
    assign prdata = {31'd0, inv_reg};

endmodule

`default_nettype wire

// ----- rtl/core/cfif_checker.sv -----
`default_nettype none

`include "centered_fft_ifft_frame_assert.svh"

module cfif_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           strobe,
    input cfif_pkg::out_t result
);
    import cfif_pkg::*;

    // Every request gets exactly one result on the following cycle.
    `CFIF_ASSERT_NEXT(a_req_gives_result, start && !busy, strobe, "request without result")
    `CFIF_ASSERT_NOW(a_result_needs_req, strobe, $past(start && !busy), "result without request")
    // With no finished frame all fields are zero.
    `CFIF_ASSERT_NOW(a_empty_is_zero, strobe && !result.out_valid, result.bin_re == '0 && result.bin_im == '0 && result.bin_index == '0 && !result.frame_end, "empty result not zero")
    // The last bin of a frame closes the frame and starts the transform.
    `CFIF_ASSERT_NOW(a_end_index, strobe && result.frame_end, result.bin_index == IDX_LAST, "frame end at wrong index")
    `CFIF_ASSERT_NOW(a_end_busy, strobe && result.frame_end, busy, "no transform after frame end")

endmodule

bind centered_fft_ifft_frame cfif_checker u_cfif_checker (.*);

`default_nettype wire
